### sv/iba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iba_pkg
// Shared types and constants of the indexed block allocator.
// ----------------------------------------------------------------------------
package iba_pkg;

  // field widths of the stream words
  localparam int CFG_W       = 7;
  localparam int MODE_W      = 2;
  localparam int BLK_FIELD_W = 6;
  localparam int STATUS_W    = 3;
  localparam int CNT_W       = 5;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 16;

  // defaults for the top-level parameters
  localparam int NUM_BLOCKS_DEF    = 64;
  localparam int MAX_PER_INDEX_DEF = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // request kinds
  typedef enum logic [MODE_W-1:0] {
    MODE_CLAIM  = 2'd0,
    MODE_ATTACH = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_t;

  // result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_INDEX_USED = 3'd1,
    ST_BLOCK_USED = 3'd2,
    ST_NOT_ALLOC  = 3'd3,
    ST_RANGE      = 3'd4,
    ST_FULL       = 3'd5
  } status_t;

  // one result word
  typedef struct packed {
    status_t          status;
    logic             used;
    logic [CNT_W-1:0] cnt;
  } res_t;

endpackage
`default_nettype wire

### sv/iba_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iba_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module iba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/iba_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iba_ctrl
// Request sequencer: range check, read-modify-write of the per-block word
// {used, length}, list append and the pipelined walk that frees a list.
// ----------------------------------------------------------------------------
module iba_ctrl
  import iba_pkg::*;
#(
  parameter int NUM_BLOCKS    = NUM_BLOCKS_DEF,
  parameter int MAX_PER_INDEX = MAX_PER_INDEX_DEF,
  localparam int BLK_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1,
  localparam int LEN_W   = $clog2(MAX_PER_INDEX + 1),
  localparam int KW      = (MAX_PER_INDEX > 1) ? $clog2(MAX_PER_INDEX) : 1,
  localparam int META_W  = 1 + LEN_W,
  localparam int LIST_AW = BLK_W + KW
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [CFG_W-1:0]       disk_blocks,
  // request side
  input  wire logic                   req_valid,
  output logic                        req_ready,
  input  wire logic [MODE_W-1:0]      req_mode,
  input  wire logic [BLK_FIELD_W-1:0] req_ib,
  input  wire logic [BLK_FIELD_W-1:0] req_db,
  // result side
  output logic                        res_valid,
  input  wire logic                   res_ready,
  output res_t                        res,
  // block word memory
  output logic [BLK_W-1:0]            meta_raddr,
  input  wire logic [META_W-1:0]      meta_rdata,
  output logic                        meta_we,
  output logic [BLK_W-1:0]            meta_waddr,
  output logic [META_W-1:0]           meta_wdata,
  // list memory
  output logic [LIST_AW-1:0]          list_raddr,
  input  wire logic [BLK_W-1:0]       list_rdata,
  output logic                        list_we,
  output logic [LIST_AW-1:0]          list_waddr,
  output logic [BLK_W-1:0]            list_wdata
);

  localparam int LIM_W = ($clog2(NUM_BLOCKS + 1) > CFG_W) ? $clog2(NUM_BLOCKS + 1) : CFG_W;
  localparam logic [LIM_W-1:0] NB_LIM   = LIM_W'(NUM_BLOCKS);
  localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_PER_INDEX);
  localparam logic [BLK_W-1:0] LAST_BLK = BLK_W'(NUM_BLOCKS - 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_META  = 7'b0000100,
    S_DBCHK = 7'b0001000,
    S_ATTW  = 7'b0010000,
    S_DEL   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  mode_t             mode_r, mode_nxt;
  logic [BLK_W-1:0]  ib_r, ib_nxt;
  logic [BLK_W-1:0]  db_r, db_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  k_r, k_nxt;
  logic              s1_v_r, s1_v_nxt;
  logic              s2_v_r, s2_v_nxt;
  logic [BLK_W-1:0]  s2_addr_r, s2_addr_nxt;
  logic [BLK_W-1:0]  clr_r, clr_nxt;
  res_t              res_r, res_nxt;

  logic [LIM_W-1:0]  lim;
  logic              oor;
  logic              m_used;
  logic [LEN_W-1:0]  m_len;

  // effective block count and range check of the incoming word
  assign lim = (LIM_W'(disk_blocks) > NB_LIM) ? NB_LIM : LIM_W'(disk_blocks);
  assign oor = (LIM_W'(req_ib) >= lim) ||
               ((req_mode == MODE_ATTACH) && (LIM_W'(req_db) >= lim));

  assign m_used = meta_rdata[META_W-1];
  assign m_len  = meta_rdata[LEN_W-1:0];

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  // block word read address
  always_comb begin
    case (state_r)
      S_META:  meta_raddr = db_r;
      S_DEL:   meta_raddr = list_rdata;
      default: meta_raddr = BLK_W'(req_ib);
    endcase
  end

  assign list_raddr = {ib_r, k_r[KW-1:0]};
  assign list_waddr = {ib_r, len_r[KW-1:0]};
  assign list_wdata = db_r;

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    ib_nxt      = ib_r;
    db_nxt      = db_r;
    len_nxt     = len_r;
    k_nxt       = k_r;
    s1_v_nxt    = 1'b0;
    s2_v_nxt    = 1'b0;
    s2_addr_nxt = s2_addr_r;
    clr_nxt     = clr_r;
    res_nxt     = res_r;
    meta_we     = 1'b0;
    meta_waddr  = ib_r;
    meta_wdata  = '0;
    list_we     = 1'b0;

    case (state_r)
      // clearing pass over the block words after reset
      S_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_r;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == LAST_BLK) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_valid) begin
          mode_nxt = mode_t'(req_mode);
          ib_nxt   = BLK_W'(req_ib);
          db_nxt   = BLK_W'(req_db);
          if (oor) begin
            res_nxt   = '{status: ST_RANGE, used: 1'b0, cnt: '0};
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_META;
          end
        end
      end

      // word of the index block is here
      S_META: begin
        state_nxt = S_DONE;
        case (mode_r)
          MODE_CLAIM: begin
            if (m_used) begin
              res_nxt = '{status: ST_INDEX_USED, used: 1'b1, cnt: CNT_W'(m_len)};
            end else begin
              meta_we    = 1'b1;
              meta_wdata = {1'b1, {LEN_W{1'b0}}};
              res_nxt    = '{status: ST_OK, used: 1'b1, cnt: '0};
            end
          end
          MODE_ATTACH: begin
            if (!m_used) begin
              res_nxt = '{status: ST_NOT_ALLOC, used: 1'b0, cnt: CNT_W'(m_len)};
            end else if (m_len >= MAX_LEN) begin
              res_nxt = '{status: ST_FULL, used: 1'b1, cnt: CNT_W'(m_len)};
            end else begin
              len_nxt   = m_len;
              state_nxt = S_DBCHK;
            end
          end
          MODE_DELETE: begin
            if (!m_used) begin
              res_nxt = '{status: ST_NOT_ALLOC, used: 1'b0, cnt: CNT_W'(m_len)};
            end else begin
              // index word cleared before the walk reads any word
              meta_we   = 1'b1;
              len_nxt   = m_len;
              k_nxt     = '0;
              res_nxt   = '{status: ST_OK, used: 1'b0, cnt: '0};
              state_nxt = S_DEL;
            end
          end
          default: begin
            res_nxt = '{status: ST_OK, used: m_used, cnt: CNT_W'(m_len)};
          end
        endcase
      end

      // word of the data block is here
      S_DBCHK: begin
        if (m_used) begin
          res_nxt   = '{status: ST_BLOCK_USED, used: 1'b1, cnt: CNT_W'(len_r)};
          state_nxt = S_DONE;
        end else begin
          meta_we    = 1'b1;
          meta_waddr = db_r;
          meta_wdata = {1'b1, m_len};
          list_we    = 1'b1;
          state_nxt  = S_ATTW;
        end
      end

      // bump the index length
      S_ATTW: begin
        meta_we    = 1'b1;
        meta_wdata = {1'b1, len_r + 1'b1};
        res_nxt    = '{status: ST_OK, used: 1'b1, cnt: CNT_W'(len_r + 1'b1)};
        state_nxt  = S_DONE;
      end

      // walk: list read, block word read, used bit cleared (length kept).
      // Overlapping words of the same block differ only in the used bit,
      // which is written to zero anyway.
      S_DEL: begin
        if (k_r < len_r) begin
          k_nxt    = k_r + 1'b1;
          s1_v_nxt = 1'b1;
        end
        s2_v_nxt    = s1_v_r;
        s2_addr_nxt = list_rdata;
        if (s2_v_r) begin
          meta_we    = 1'b1;
          meta_waddr = s2_addr_r;
          meta_wdata = {1'b0, m_len};
        end
        if ((k_r == len_r) && !s1_v_r && !s2_v_r) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    ib_r      <= ib_nxt;
    db_r      <= db_nxt;
    len_r     <= len_nxt;
    k_r       <= k_nxt;
    s2_addr_r <= s2_addr_nxt;
    res_r     <= res_nxt;
  end

endmodule
`default_nettype wire

### sv/indexed_block_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// A range error goes straight to the result word; claim and query read the index
// word; attach also reads the data block word, then bumps the index length;
// delete does a three-stage read/read/write walk of the two memories.
// One request in flight; the next word is taken once the result is registered.
// Reset: synchronous; a clearing pass over all NUM_BLOCKS block words then zeroes the
// block word memory, with in_tready low until it ends.
// ----------------------------------------------------------------------------
// indexed_block_allocator
// Indexed block allocation with a used-block map and per-index block lists.
// ----------------------------------------------------------------------------
module indexed_block_allocator
  import iba_pkg::*;
#(
  parameter int NUM_BLOCKS    = NUM_BLOCKS_DEF,
  parameter int MAX_PER_INDEX = MAX_PER_INDEX_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_W-1:0]      cfg_wdata,    // disk_blocks
  // requests
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,     // index_block[5:0], data_block[11:6]
  input  wire logic [MODE_W-1:0]     in_tuser,     // mode[1:0]
  // results
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata     // status[2:0], block_used[3],
                                                   // attached_count[8:4]
);

  localparam int BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int LEN_W      = $clog2(MAX_PER_INDEX + 1);
  localparam int KW         = (MAX_PER_INDEX > 1) ? $clog2(MAX_PER_INDEX) : 1;
  localparam int META_W     = 1 + LEN_W;
  localparam int LIST_AW    = BLK_W + KW;
  localparam int LIST_DEPTH = NUM_BLOCKS << KW;

  logic [CFG_W-1:0]   cfg_r, cfg_nxt;
  logic               out_v_r, out_v_nxt;
  res_t               out_res_r, out_res_nxt;

  logic               res_valid, res_ready;
  res_t               res;

  logic [BLK_W-1:0]   meta_raddr, meta_waddr;
  logic [META_W-1:0]  meta_rdata, meta_wdata;
  logic               meta_we;
  logic [LIST_AW-1:0] list_raddr, list_waddr;
  logic [BLK_W-1:0]   list_rdata, list_wdata;
  logic               list_we;

  // configuration register
  assign cfg_nxt = cfg_we ? cfg_wdata : cfg_r;

  // output register
  assign res_ready   = !out_v_r || out_tready;
  assign out_v_nxt   = res_valid ? 1'b1 : (out_v_r && !out_tready);
  assign out_res_nxt = (res_valid && res_ready) ? res : out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r   <= CFG_RESET;
      out_v_r <= 1'b0;
    end else begin
      cfg_r   <= cfg_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_DATA_W - STATUS_W - 1 - CNT_W){1'b0}},
                       out_res_r.cnt, out_res_r.used, out_res_r.status};

  iba_ctrl #(
    .NUM_BLOCKS    (NUM_BLOCKS),
    .MAX_PER_INDEX (MAX_PER_INDEX)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .disk_blocks (cfg_r),
    .req_valid   (in_tvalid),
    .req_ready   (in_tready),
    .req_mode    (in_tuser),
    .req_ib      (in_tdata[BLK_FIELD_W-1:0]),
    .req_db      (in_tdata[2*BLK_FIELD_W-1:BLK_FIELD_W]),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .meta_raddr  (meta_raddr),
    .meta_rdata  (meta_rdata),
    .meta_we     (meta_we),
    .meta_waddr  (meta_waddr),
    .meta_wdata  (meta_wdata),
    .list_raddr  (list_raddr),
    .list_rdata  (list_rdata),
    .list_we     (list_we),
    .list_waddr  (list_waddr),
    .list_wdata  (list_wdata)
  );

  // per-block word {used, list length}
  iba_ram #(
    .WIDTH (META_W),
    .DEPTH (NUM_BLOCKS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  // attached block lists, one row of 2**KW slots (at least MAX_PER_INDEX) per index
  iba_ram #(
    .WIDTH (BLK_W),
    .DEPTH (LIST_DEPTH)
  ) u_list_ram (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (list_wdata),
    .raddr (list_raddr),
    .rdata (list_rdata)
  );

endmodule
`default_nettype wire
